FILE: hdl/spkeq_pkg.sv
// Shared types, constants and helpers for the speaker high-pass + peaking EQ.
// Used by spkeq_mac, the top level and the checker.
// No dependencies.
package spkeq_pkg;

  localparam int COEF_FRAC_BITS  = 14;
  localparam int STATE_FRAC_BITS = 8;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int STATE_W  = 32;
  localparam int COEF_W   = 17;             // one extra bit so -a1/-a2 never overflow
  localparam int OPND_W   = 34;             // wide enough for the 33-bit high-pass pre-sum
  localparam int PROD_W   = COEF_W + OPND_W;
  localparam int ACC_W    = PROD_W + 2;     // five biquad terms
  localparam int MAC_TERMS = 5;
  localparam int IDX_W    = 3;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd6;

  // input function codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // reset coefficients
  localparam logic signed [CFG_W-1:0] RST_HP_ALPHA = 16'sd15188;
  localparam logic signed [CFG_W-1:0] RST_COEF_B0  = 16'sd18607;
  localparam logic signed [CFG_W-1:0] RST_COEF_B1  = -16'sd19964;
  localparam logic signed [CFG_W-1:0] RST_COEF_B2  = 16'sd6555;
  localparam logic signed [CFG_W-1:0] RST_COEF_A1  = -16'sd19964;
  localparam logic signed [CFG_W-1:0] RST_COEF_A2  = 16'sd8780;

  // int16 limits in state format
  localparam logic signed [STATE_W-1:0] Y_HI = 32'(32767 * (2 ** STATE_FRAC_BITS));
  localparam logic signed [STATE_W-1:0] Y_LO = 32'(-32768 * (2 ** STATE_FRAC_BITS));
  localparam logic [STATE_W:0] TRUNC_BIAS = 33'((2 ** STATE_FRAC_BITS) - 1);

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } mac_ctl_t;

  // floor shift by the coefficient fraction, then saturate to int32
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    sh = v >>> COEF_FRAC_BITS;
    hi = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    lo = {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    if (sh > hi) begin
      return hi[STATE_W-1:0];
    end else if (sh < lo) begin
      return lo[STATE_W-1:0];
    end
    return sh[STATE_W-1:0];
  endfunction

endpackage

FILE: hdl/spkeq_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on spkeq_pkg.
module spkeq_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  spkeq_pkg::mac_ctl_t                 ctl,
  input  logic signed [spkeq_pkg::COEF_W-1:0] coef,
  input  logic signed [spkeq_pkg::OPND_W-1:0] opnd,
  output logic signed [spkeq_pkg::PROD_W-1:0] prod,
  output logic signed [spkeq_pkg::ACC_W-1:0]  acc
);

  logic signed [spkeq_pkg::ACC_W-1:0] prod_ext;

  assign prod_ext = {{(spkeq_pkg::ACC_W-spkeq_pkg::PROD_W){prod[spkeq_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= coef * opnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + prod_ext;
    end
  end

endmodule

FILE: hdl/speaker_highpass_peaking_eq.sv
// Top level: one-pole high-pass followed by a direct-form-I peaking biquad.
// Depends on spkeq_pkg and spkeq_mac.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, func, sample_in       | request in
//  out     | out_valid, out_ready, sample_out, clipped | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// A filtered sample holds the block from acceptance until hand-off: one
// pre-add, six passes through the single 17x34 multiplier (high-pass and
// five biquad taps), the accumulate tail, saturation, clip and hand-off.
// A clear request leaves it ready again in the next cycle; bypass goes straight to hand-off.
// Reset zeroes the filter history and loads the default coefficients.
// A stalled output holds its result; the next request is taken meanwhile.
module speaker_highpass_peaking_eq (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic signed [spkeq_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [spkeq_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                   clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [spkeq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spkeq_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_HPMUL, S_HPSAT, S_MAC, S_ACCL, S_YSAT, S_RES, S_OUT
  } state_t;

  state_t state;
  logic [spkeq_pkg::IDX_W-1:0] idx;

  logic                                  bypass;
  logic signed [spkeq_pkg::CFG_W-1:0]    hp_alpha, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic signed [spkeq_pkg::SAMPLE_W-1:0] x_reg;
  logic signed [spkeq_pkg::SAMPLE_W-1:0] hp_last_input;
  logic signed [spkeq_pkg::STATE_W-1:0]  hp_last_output;
  logic signed [spkeq_pkg::STATE_W-1:0]  d_in1, d_in2, d_out1, d_out2;
  logic signed [spkeq_pkg::OPND_W-1:0]   hp_opnd;
  logic signed [spkeq_pkg::SAMPLE_W-1:0] res_value;
  logic                                  res_clip;

  spkeq_pkg::mac_ctl_t                   mac_ctl;
  logic signed [spkeq_pkg::COEF_W-1:0]   mac_coef;
  logic signed [spkeq_pkg::OPND_W-1:0]   mac_opnd;
  logic signed [spkeq_pkg::PROD_W-1:0]   mac_prod;
  logic signed [spkeq_pkg::ACC_W-1:0]    mac_acc;
  logic signed [spkeq_pkg::ACC_W-1:0]    prod_ext;

  logic signed [spkeq_pkg::SAMPLE_W:0]   x_diff;
  logic signed [spkeq_pkg::OPND_W-1:0]   hp_sum;
  logic signed [spkeq_pkg::STATE_W-1:0]  tap_val;
  logic signed [spkeq_pkg::STATE_W:0]    y_biased;
  logic signed [spkeq_pkg::STATE_W:0]    y_trunc;
  logic                                  in_fire;
  logic                                  out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // hp pre-sum: last output + (x - x_prev) in state format
  assign x_diff = {x_reg[spkeq_pkg::SAMPLE_W-1], x_reg}
                - {hp_last_input[spkeq_pkg::SAMPLE_W-1], hp_last_input};
  assign hp_sum = {{(spkeq_pkg::OPND_W-spkeq_pkg::STATE_W){hp_last_output[spkeq_pkg::STATE_W-1]}},
                   hp_last_output}
                + {{(spkeq_pkg::OPND_W-spkeq_pkg::SAMPLE_W-1-spkeq_pkg::STATE_FRAC_BITS)
                    {x_diff[spkeq_pkg::SAMPLE_W]}},
                   x_diff, {spkeq_pkg::STATE_FRAC_BITS{1'b0}}};

  assign prod_ext = {{(spkeq_pkg::ACC_W-spkeq_pkg::PROD_W){mac_prod[spkeq_pkg::PROD_W-1]}},
                     mac_prod};

  // truncation toward zero
  assign y_biased = {d_out1[spkeq_pkg::STATE_W-1], d_out1}
                  + (d_out1[spkeq_pkg::STATE_W-1] ? spkeq_pkg::TRUNC_BIAS : '0);
  assign y_trunc  = y_biased >>> spkeq_pkg::STATE_FRAC_BITS;

  always_comb begin
    mac_ctl  = '0;
    mac_coef = '0;
    tap_val  = '0;
    case (idx)
      3'd0:    begin mac_coef = {coef_b0[15], coef_b0};     tap_val = hp_last_output; end
      3'd1:    begin mac_coef = {coef_b1[15], coef_b1};     tap_val = d_in1;          end
      3'd2:    begin mac_coef = {coef_b2[15], coef_b2};     tap_val = d_in2;          end
      3'd3:    begin mac_coef = -{coef_a1[15], coef_a1};    tap_val = d_out1;         end
      default: begin mac_coef = -{coef_a2[15], coef_a2};    tap_val = d_out2;         end
    endcase
    mac_opnd = {{(spkeq_pkg::OPND_W-spkeq_pkg::STATE_W){tap_val[spkeq_pkg::STATE_W-1]}}, tap_val};
    if (state == S_HPMUL) begin
      mac_coef = {hp_alpha[15], hp_alpha};
      mac_opnd = hp_opnd;
    end
    mac_ctl.mul_en  = (state == S_HPMUL) || (state == S_MAC);
    mac_ctl.acc_clr = (state == S_MAC) && (idx == '0);
    mac_ctl.acc_add = ((state == S_MAC) && (idx != '0)) || (state == S_ACCL);
  end

  spkeq_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (mac_coef),
    .opnd (mac_opnd),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass   <= 1'b0;
      hp_alpha <= spkeq_pkg::RST_HP_ALPHA;
      coef_b0  <= spkeq_pkg::RST_COEF_B0;
      coef_b1  <= spkeq_pkg::RST_COEF_B1;
      coef_b2  <= spkeq_pkg::RST_COEF_B2;
      coef_a1  <= spkeq_pkg::RST_COEF_A1;
      coef_a2  <= spkeq_pkg::RST_COEF_A2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spkeq_pkg::REG_BYPASS:   bypass   <= cfg_data[0];
        spkeq_pkg::REG_HP_ALPHA: hp_alpha <= cfg_data;
        spkeq_pkg::REG_COEF_B0:  coef_b0  <= cfg_data;
        spkeq_pkg::REG_COEF_B1:  coef_b1  <= cfg_data;
        spkeq_pkg::REG_COEF_B2:  coef_b2  <= cfg_data;
        spkeq_pkg::REG_COEF_A1:  coef_a1  <= cfg_data;
        spkeq_pkg::REG_COEF_A2:  coef_a2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers with no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_reg <= sample_in;
    end
    if (state == S_PREP) begin
      hp_opnd <= hp_sum;
    end
  end

  // sequencer, history and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      hp_last_input  <= '0;
      hp_last_output <= '0;
      d_in1          <= '0;
      d_in2          <= '0;
      d_out1         <= '0;
      d_out2         <= '0;
      res_value      <= '0;
      res_clip       <= 1'b0;
      out_valid      <= 1'b0;
      sample_out     <= '0;
      clipped        <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (func == spkeq_pkg::FUNC_CLEAR) begin
              hp_last_input  <= '0;
              hp_last_output <= '0;
              d_in1          <= '0;
              d_in2          <= '0;
              d_out1         <= '0;
              d_out2         <= '0;
            end else if (bypass) begin
              res_value <= sample_in;
              res_clip  <= 1'b0;
              state     <= S_OUT;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP:  state <= S_HPMUL;
        S_HPMUL: state <= S_HPSAT;
        S_HPSAT: begin
          hp_last_output <= spkeq_pkg::sat_state(prod_ext);
          hp_last_input  <= x_reg;
          idx            <= '0;
          state          <= S_MAC;
        end
        S_MAC: begin
          if (idx == spkeq_pkg::IDX_W'(spkeq_pkg::MAC_TERMS - 1)) begin
            idx   <= '0;
            state <= S_ACCL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ACCL: state <= S_YSAT;
        S_YSAT: begin
          d_in2  <= d_in1;
          d_in1  <= hp_last_output;
          d_out2 <= d_out1;
          d_out1 <= spkeq_pkg::sat_state(mac_acc);
          state  <= S_RES;
        end
        S_RES: begin
          if (d_out1 > spkeq_pkg::Y_HI) begin
            res_value <= 16'sh7fff;
            res_clip  <= 1'b1;
          end else if (d_out1 < spkeq_pkg::Y_LO) begin
            res_value <= 16'sh8000;
            res_clip  <= 1'b1;
          end else begin
            res_value <= y_trunc[spkeq_pkg::SAMPLE_W-1:0];
            res_clip  <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            sample_out <= res_value;
            clipped    <= res_clip;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/spkeq_checker.sv
// Port-level checker for speaker_highpass_peaking_eq, bound to the top level.
// Depends on spkeq_pkg.
module spkeq_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  func,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [spkeq_pkg::SAMPLE_W-1:0] sample_out,
  input logic                                  clipped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("result changed while stalled");

  // the block is ready again in the cycle after a clear
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == spkeq_pkg::FUNC_CLEAR) |=> in_ready)
    else $error("not ready after clear request");

  // a sample keeps the block busy
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == spkeq_pkg::FUNC_FILTER) |=> !in_ready)
    else $error("ready right after sample request");

  // a clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample_out == 16'sh7fff) || (sample_out == 16'sh8000))
    else $error("clipped result not at int16 limit");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind speaker_highpass_peaking_eq spkeq_checker u_spkeq_checker (.*);

FILE: sim/tb_speaker_highpass_peaking_eq.sv
// Self-checking testbench for speaker_highpass_peaking_eq: high-pass plus peaking biquad.
// A bit-exact predictor runs on each accepted request; results are compared field by field.
// Depends on spkeq_pkg and the RTL under hdl/.
module tb_speaker_highpass_peaking_eq;
  timeunit 1ns;
  timeprecision 1ps;
  import spkeq_pkg::*;

  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN       = 20;
  localparam int     LONG_HOLD   = 400;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -S32_MAX - 1;

  typedef struct {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } eq_request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } eq_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FUNC_FILTER;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_BYPASS;
  logic [CFG_W-1:0]           cfg_data = '0;

  speaker_highpass_peaking_eq i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .clipped   (clipped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  eq_request_t request_queue[$];
  eq_result_t  eq_expected[$];
  int          errors = 0;
  int          cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  logic        in_taken = 1'b0;

  // predictor copy of registers and filter history
  bit     eq_bypass = 1'b0;
  longint eq_alpha = RST_HP_ALPHA;
  longint eq_b0 = RST_COEF_B0;
  longint eq_b1 = RST_COEF_B1;
  longint eq_b2 = RST_COEF_B2;
  longint eq_a1 = RST_COEF_A1;
  longint eq_a2 = RST_COEF_A2;
  longint hp_prev_in = 0, hp_prev_out = 0;
  longint eq_x1 = 0, eq_x2 = 0, eq_y1 = 0, eq_y2 = 0;

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  task automatic eq_predict(input logic f, input logic signed [SAMPLE_W-1:0] x);
    longint     xs;
    longint     acc;
    longint     hp;
    longint     y;
    eq_result_t r;
    if (f == FUNC_CLEAR) begin
      hp_prev_in = 0;
      hp_prev_out = 0;
      eq_x1 = 0;
      eq_x2 = 0;
      eq_y1 = 0;
      eq_y2 = 0;
      return;
    end
    xs = x;
    if (eq_bypass) begin
      r.sample = x;
      r.clip = 1'b0;
      eq_expected.push_back(r);
      return;
    end
    acc = hp_prev_out + (xs <<< STATE_FRAC_BITS) - (hp_prev_in <<< STATE_FRAC_BITS);
    hp = clamp32((eq_alpha * acc) >>> COEF_FRAC_BITS);
    hp_prev_in = xs;
    hp_prev_out = hp;
    acc = eq_b0 * hp + eq_b1 * eq_x1 + eq_b2 * eq_x2 - eq_a1 * eq_y1 - eq_a2 * eq_y2;
    y = clamp32(acc >>> COEF_FRAC_BITS);
    eq_x2 = eq_x1;
    eq_x1 = hp;
    eq_y2 = eq_y1;
    eq_y1 = y;
    if (y > (longint'(32767) <<< STATE_FRAC_BITS)) begin
      r.sample = 16'sh7fff;
      r.clip = 1'b1;
    end else if (y < (longint'(-32768) <<< STATE_FRAC_BITS)) begin
      r.sample = 16'sh8000;
      r.clip = 1'b1;
    end else begin
      // truncate toward zero
      r.sample = (y >= 0) ? SAMPLE_W'(y >>> STATE_FRAC_BITS)
                          : SAMPLE_W'(-((-y) >>> STATE_FRAC_BITS));
      r.clip = 1'b0;
    end
    eq_expected.push_back(r);
  endtask

  // request driver
  always @(negedge clk) begin
    eq_request_t req;
    logic        nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
      end else if (request_queue.size() > 0) begin
        req = request_queue.pop_front();
        func <= req.func;
        sample_in <= req.sample;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // result receiver
  always @(negedge clk) begin
    logic r;
    r = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
    end else if (out_gap > 0) begin
      out_gap--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
    end else begin
      r = 1'b1;
    end
    out_ready <= r;
  end

  // monitor: check results, then predict for the accepted request
  always @(posedge clk) begin
    eq_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (eq_expected.size() == 0) begin
          $display("%0t: result with none pending: sample_out=%0d clipped=%0b",
                   $time, sample_out, clipped);
          errors++;
        end else begin
          e = eq_expected.pop_front();
          if (sample_out !== e.sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, sample_out);
            errors++;
          end
          if (clipped !== e.clip) begin
            $display("%0t: clipped expected %0b actual %0b", $time, e.clip, clipped);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) eq_predict(func, sample_in);
      in_taken <= in_valid && in_ready;
    end
  end

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
    eq_request_t req;
    req.func = FUNC_FILTER;
    req.sample = x;
    request_queue.push_back(req);
  endtask

  task automatic push_clear();
    eq_request_t req;
    req.func = FUNC_CLEAR;
    req.sample = SAMPLE_W'($urandom);  // ignored by the block
    request_queue.push_back(req);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) push_clear();
      else push_sample(rand_sample());
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_coef(input logic [CFG_W-1:0] nominal,
                                                 input bit near);
    if (near) return nominal + CFG_W'($urandom_range(0, 512)) - 16'd256;
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // block must be idle: all requests taken, all results back, pipeline drained
  task automatic wait_idle();
    while (request_queue.size() > 0 || in_valid || eq_expected.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BYPASS:   eq_bypass = val[0];
      REG_HP_ALPHA: eq_alpha = longint'($signed(val));
      REG_COEF_B0:  eq_b0 = longint'($signed(val));
      REG_COEF_B1:  eq_b1 = longint'($signed(val));
      REG_COEF_B2:  eq_b2 = longint'($signed(val));
      REG_COEF_A1:  eq_a1 = longint'($signed(val));
      REG_COEF_A2:  eq_a2 = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic byp, input logic [CFG_W-1:0] alpha,
                                input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
                                input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
                                input logic [CFG_W-1:0] a2);
    cfg_write(REG_BYPASS, {15'd0, byp});
    cfg_write(REG_HP_ALPHA, alpha);
    cfg_write(REG_COEF_B0, b0);
    cfg_write(REG_COEF_B1, b1);
    cfg_write(REG_COEF_B2, b2);
    cfg_write(REG_COEF_A1, a1);
    cfg_write(REG_COEF_A2, a2);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit near;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: extremes, steps, alternation, clear mid-stream
    push_sample(16'sd0);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sd1);
    push_sample(-16'sd1);
    push_clear();
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
    push_clear();
    wait_idle();

    // bypass keeps history untouched; a clear still zeroes it
    apply_settings(1'b1, RST_HP_ALPHA, RST_COEF_B0, RST_COEF_B1, RST_COEF_B2,
                   RST_COEF_A1, RST_COEF_A2);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sd0);
    push_clear();
    push_sample(-16'sd1);
    wait_idle();

    // extreme coefficients drive y into 32-bit saturation
    apply_settings(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    wait_idle();
    apply_settings(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      near = (p % 2 == 0);
      apply_settings($urandom_range(0, 4) == 0, pick_coef(RST_HP_ALPHA, near),
                     pick_coef(RST_COEF_B0, near), pick_coef(RST_COEF_B1, near),
                     pick_coef(RST_COEF_B2, near), pick_coef(RST_COEF_A1, near),
                     pick_coef(RST_COEF_A2, near));
      idle_en = (p % 4 != 3);
      push_random(140);
      // receiver holds off while the sender keeps offering requests
      if (p == 4) hold_req = 1'b1;
      wait_idle();
    end

    // last stretch at full rate
    idle_en = 1'b0;
    apply_settings(1'b0, RST_HP_ALPHA, RST_COEF_B0, RST_COEF_B1, RST_COEF_B2,
                   RST_COEF_A1, RST_COEF_A2);
    push_random(150);
    while (request_queue.size() > 0 || in_valid || eq_expected.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && eq_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
